// ===== rtl/kmi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmi_pkg
// Shared types and codes of the keyframe matrix interpolator.
// ----------------------------------------------------------------------------
package kmi_pkg;

   localparam int unsigned ElemCount = 16;

   typedef enum logic [1:0] {
      KIND_LOAD_TIME   = 2'd0,
      KIND_LOAD_MATRIX = 2'd1,
      KIND_EVALUATE    = 2'd2,
      KIND_RESERVED    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REGION_BETWEEN = 2'd0,
      REGION_FIRST   = 2'd1,
      REGION_LAST    = 2'd2,
      REGION_UNUSED  = 2'd3
   } region_type;

   localparam logic CSR_INTERP_MODE = 1'b0;
   localparam logic CSR_KEY_COUNT   = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  key_slot;
      logic [3:0]  element_slot;
      logic [31:0] element_value;
      logic [31:0] time_value;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_element;
      logic [31:0] out_value;
      logic [1:0]  region;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/kmi_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmi_req_if
// Request channel: valid, ready and one request payload.
// ----------------------------------------------------------------------------
interface kmi_req_if;
   logic            valid;
   logic            ready;
   kmi_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/kmi_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmi_rsp_if
// Result channel: valid, ready and one result payload.
// ----------------------------------------------------------------------------
interface kmi_rsp_if;
   logic            valid;
   logic            ready;
   kmi_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/keyframe_matrix_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_matrix_interpolator
// Keyframe table of times and 4x4 matrices, evaluated by step or linear blend.
// ----------------------------------------------------------------------------
// Requests come in on req (valid/ready). A load time or load matrix request
// writes one memory entry at the edge that accepts it, so loads can follow
// back to back. An evaluate request scans the key time memory in two steps
// per key (read, compare), up to key_count keys (clamped to 1..MAX_KEYS).
// In linear mode between two keys it then reads the earlier key time and
// runs a (32 + FRAC_BITS)-step bit-serial fraction divider. It then emits
// sixteen results on rsp, in five steps per element (read right, read
// left, subtract, multiply, add). One request is worked on at a time; req
// is ready only when idle. The result register holds its value while
// rsp.ready is low, and the block waits before reading the next element
// until the result is taken. Reset clears the control state and sets
// interp_mode to 1 and key_count to 1; the memories are not cleared and
// must be written before they are read. csr writes are taken on any cycle
// with csr_write.
// ----------------------------------------------------------------------------
module keyframe_matrix_interpolator #(
   parameter int unsigned MAX_KEYS  = 64,
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   kmi_req_if.sink          req,
   kmi_rsp_if.source        rsp,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);
   import kmi_pkg::*;

   localparam int unsigned KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int unsigned NW = $clog2(MAX_KEYS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_TL_RD, ST_TL_CMP, ST_DIV,
      ST_E_RD_R, ST_E_RD_L, ST_E_MUL, ST_E_PROD, ST_E_OUT
   } state_type;

   state_type state_ff;
   logic      mode_ff;
   logic [6:0] count_ff;
   req_type   cur_ff;
   logic [KW-1:0] idx_ff;
   logic [KW-1:0] sel_ff;
   logic [1:0]    region_ff;
   logic          blend_ff;
   logic [31:0]   tr_ff;
   logic [3:0]    elem_ff;
   logic [31:0]   rv_ff;
   logic signed [32:0] delta_ff;
   logic [FRAC_BITS:0] s_ff;
   logic signed [33+FRAC_BITS+1:0] prod_ff;
   logic [31:0]   lv_ff;
   rsp_type       out_ff;
   logic          out_valid_ff;

   logic [31:0] time_mem [MAX_KEYS];
   logic [31:0] mat_mem  [MAX_KEYS*16];
   logic [31:0] time_rd_ff;
   logic [31:0] mat_rd_ff;
   logic [KW-1:0] time_addr;
   logic [KW+3:0] mat_addr;

   logic [NW-1:0] n_use;
   logic          div_start, div_done;
   logic [FRAC_BITS:0] div_q;
   logic          slot_ok;

   always_comb begin
      if (count_ff == 7'd0) begin
         n_use = NW'(1);
      end else if ({25'd0, count_ff} > 32'(MAX_KEYS)) begin
         n_use = NW'(MAX_KEYS);
      end else begin
         n_use = NW'(count_ff);
      end
   end

   assign slot_ok = ({26'd0, req.payload.key_slot} < 32'(MAX_KEYS));

   kmi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (cur_ff.time_value - time_rd_ff),
      .den   (tr_ff - time_rd_ff),
      .done  (div_done),
      .quot  (div_q)
   );
   assign div_start = (state_ff == ST_TL_CMP);

   always_comb begin
      time_addr = idx_ff;
      if (state_ff == ST_TL_RD) begin
         time_addr = idx_ff - 1'b1;
      end
      mat_addr = {sel_ff, elem_ff};
      if (state_ff == ST_E_RD_L) begin
         mat_addr = {sel_ff - 1'b1, elem_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && slot_ok) begin
         if (req.payload.kind == KIND_LOAD_TIME) begin
            time_mem[KW'(req.payload.key_slot)] <= req.payload.time_value;
         end
         if (req.payload.kind == KIND_LOAD_MATRIX) begin
            mat_mem[{KW'(req.payload.key_slot), req.payload.element_slot}]
               <= req.payload.element_value;
         end
      end
      time_rd_ff <= time_mem[time_addr];
      mat_rd_ff  <= mat_mem[mat_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b1;
         count_ff     <= 7'd1;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_INTERP_MODE: mode_ff  <= csr_data[0];
               CSR_KEY_COUNT:   count_ff <= csr_data;
               default: ;
            endcase
         end
         if (out_valid_ff && rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  cur_ff <= req.payload;
                  idx_ff <= '0;
                  elem_ff <= '0;
                  if (req.payload.kind == KIND_EVALUATE) begin
                     state_ff <= ST_SCAN_RD;
                  end
               end
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_CMP;
            ST_SCAN_CMP: begin
               // memory data here belongs to key idx_ff
               if (!(time_rd_ff < cur_ff.time_value)) begin
                  sel_ff <= idx_ff;
                  tr_ff  <= time_rd_ff;
                  if (idx_ff == '0) begin
                     region_ff <= REGION_FIRST;
                     blend_ff  <= 1'b0;
                     state_ff  <= ST_E_RD_R;
                  end else begin
                     region_ff <= REGION_BETWEEN;
                     blend_ff  <= mode_ff;
                     state_ff  <= mode_ff ? ST_TL_RD : ST_E_RD_R;
                  end
               end else if (NW'(idx_ff) == NW'(n_use - 1'b1)) begin
                  sel_ff    <= idx_ff;
                  region_ff <= REGION_LAST;
                  blend_ff  <= 1'b0;
                  state_ff  <= ST_E_RD_R;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_TL_RD:  state_ff <= ST_TL_CMP;
            ST_TL_CMP: state_ff <= ST_DIV;
            ST_DIV: begin
               if (div_done) begin
                  s_ff     <= div_q;
                  state_ff <= ST_E_RD_R;
               end
            end
            ST_E_RD_R: begin
               if (!out_valid_ff || rsp.ready) begin
                  state_ff <= ST_E_RD_L;
               end
            end
            ST_E_RD_L: begin
               rv_ff    <= mat_rd_ff;
               state_ff <= ST_E_MUL;
            end
            ST_E_MUL: begin
               lv_ff    <= mat_rd_ff;
               delta_ff <= $signed({rv_ff[31], rv_ff}) - $signed({mat_rd_ff[31], mat_rd_ff});
               state_ff <= ST_E_PROD;
            end
            // product of this element lands in prod_ff at the end of this cycle
            ST_E_PROD: state_ff <= ST_E_OUT;
            ST_E_OUT: begin
               out_valid_ff      <= 1'b1;
               out_ff.out_element <= elem_ff;
               out_ff.region     <= region_ff;
               out_ff.last       <= (elem_ff == 4'd15);
               if (blend_ff) begin
                  out_ff.out_value <= lv_ff + 32'(prod_ff >>> FRAC_BITS);
               end else begin
                  out_ff.out_value <= rv_ff;
               end
               elem_ff  <= elem_ff + 1'b1;
               state_ff <= (elem_ff == 4'd15) ? ST_IDLE : ST_E_RD_R;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // product register sits between the subtract and the final add
   always_ff @(posedge clock) begin
      prod_ff <= delta_ff * $signed({1'b0, s_ff});
   end

   assign req.ready   = (state_ff == ST_IDLE) && !reset;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule
`default_nettype wire

// ===== rtl/kmi_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmi_divider
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
module kmi_divider #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [31:0]            num,
   input  wire logic [31:0]            den,
   output logic                        done,
   output logic [FRAC_BITS:0]          quot
);
   localparam int unsigned QW = 32 + FRAC_BITS;
   localparam int unsigned CW = $clog2(QW + 1);

   logic [QW-1:0] dividend_ff, dividend_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic [32:0]   diff;

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      trial       = {rem_ff[31:0], dividend_ff[QW-1]};
      diff        = trial - {1'b0, den_ff};
      if (start) begin
         dividend_in = {num, {FRAC_BITS{1'b0}}};
         rem_in      = '0;
         den_in      = den;
         count_in    = CW'(QW);
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff;
         end else begin
            rem_in = trial;
         end
         dividend_in = {dividend_ff[QW-2:0], ~diff[32]};
         count_in    = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
   end

   assign done = done_ff;
   // quotient never exceeds one, so the low bits carry it
   assign quot = dividend_ff[FRAC_BITS:0];
endmodule
`default_nettype wire
